// ===== hdl/acs_pkg.sv =====
// Package: character tables and shaping functions for the Arabic contextual shaper.
`timescale 1ns / 1ps
`default_nettype none

package acs_pkg;

  localparam int SHAPE_ROWS = 49;
  localparam int MARK_ROWS  = 39;
  localparam int ALEF_ROWS  = 4;

  localparam logic [15:0] LAM     = 16'h0644;
  localparam logic [15:0] TATWEEL = 16'h0640;

  typedef struct packed {
    logic        is_mark;
    logic        is_letter;
    logic [15:0] isol;
    logic [15:0] init;
    logic [15:0] medi;
    logic [15:0] fina;
  } char_info_t;

  // code, isolated, initial, medial, final
  localparam logic [15:0] SHAPE_TAB [SHAPE_ROWS][5] = '{
    '{16'h0621, 16'hFE80, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0622, 16'hFE81, 16'h0000, 16'h0000, 16'hFE82},
    '{16'h0623, 16'hFE83, 16'h0000, 16'h0000, 16'hFE84},
    '{16'h0624, 16'hFE85, 16'h0000, 16'h0000, 16'hFE86},
    '{16'h0625, 16'hFE87, 16'h0000, 16'h0000, 16'hFE88},
    '{16'h0626, 16'hFE89, 16'hFE8B, 16'hFE8C, 16'hFE8A},
    '{16'h0627, 16'hFE8D, 16'h0000, 16'h0000, 16'hFE8E},
    '{16'h0628, 16'hFE8F, 16'hFE91, 16'hFE92, 16'hFE90},
    '{16'h0629, 16'hFE93, 16'h0000, 16'h0000, 16'hFE94},
    '{16'h062A, 16'hFE95, 16'hFE97, 16'hFE98, 16'hFE96},
    '{16'h062B, 16'hFE99, 16'hFE9B, 16'hFE9C, 16'hFE9A},
    '{16'h062C, 16'hFE9D, 16'hFE9F, 16'hFEA0, 16'hFE9E},
    '{16'h062D, 16'hFEA1, 16'hFEA3, 16'hFEA4, 16'hFEA2},
    '{16'h062E, 16'hFEA5, 16'hFEA7, 16'hFEA8, 16'hFEA6},
    '{16'h062F, 16'hFEA9, 16'h0000, 16'h0000, 16'hFEAA},
    '{16'h0630, 16'hFEAB, 16'h0000, 16'h0000, 16'hFEAC},
    '{16'h0631, 16'hFEAD, 16'h0000, 16'h0000, 16'hFEAE},
    '{16'h0632, 16'hFEAF, 16'h0000, 16'h0000, 16'hFEB0},
    '{16'h0633, 16'hFEB1, 16'hFEB3, 16'hFEB4, 16'hFEB2},
    '{16'h0634, 16'hFEB5, 16'hFEB7, 16'hFEB8, 16'hFEB6},
    '{16'h0635, 16'hFEB9, 16'hFEBB, 16'hFEBC, 16'hFEBA},
    '{16'h0636, 16'hFEBD, 16'hFEBF, 16'hFEC0, 16'hFEBE},
    '{16'h0637, 16'hFEC1, 16'hFEC3, 16'hFEC4, 16'hFEC2},
    '{16'h0638, 16'hFEC5, 16'hFEC7, 16'hFEC8, 16'hFEC6},
    '{16'h0639, 16'hFEC9, 16'hFECB, 16'hFECC, 16'hFECA},
    '{16'h063A, 16'hFECD, 16'hFECF, 16'hFED0, 16'hFECE},
    '{16'h0640, 16'h0640, 16'h0000, 16'h0000, 16'h0000},
    '{16'h0641, 16'hFED1, 16'hFED3, 16'hFED4, 16'hFED2},
    '{16'h0642, 16'hFED5, 16'hFED7, 16'hFED8, 16'hFED6},
    '{16'h0643, 16'hFED9, 16'hFEDB, 16'hFEDC, 16'hFEDA},
    '{16'h0644, 16'hFEDD, 16'hFEDF, 16'hFEE0, 16'hFEDE},
    '{16'h0645, 16'hFEE1, 16'hFEE3, 16'hFEE4, 16'hFEE2},
    '{16'h0646, 16'hFEE5, 16'hFEE7, 16'hFEE8, 16'hFEE6},
    '{16'h0647, 16'hFEE9, 16'hFEEB, 16'hFEEC, 16'hFEEA},
    '{16'h0648, 16'hFEED, 16'h0000, 16'h0000, 16'hFEEE},
    '{16'h0649, 16'hFEEF, 16'hFEF3, 16'hFEF4, 16'hFEF0},
    '{16'h064A, 16'hFEF1, 16'hFEF3, 16'hFEF4, 16'hFEF2},
    '{16'h0679, 16'hFB66, 16'hFB68, 16'hFB69, 16'hFB67},
    '{16'h067E, 16'hFB56, 16'hFB58, 16'hFB59, 16'hFB57},
    '{16'h0686, 16'hFB7A, 16'hFB7C, 16'hFB7D, 16'hFB7B},
    '{16'h0688, 16'hFB88, 16'h0000, 16'h0000, 16'hFB89},
    '{16'h0691, 16'hFB8C, 16'h0000, 16'h0000, 16'hFB8D},
    '{16'h0698, 16'hFB8A, 16'h0000, 16'h0000, 16'hFB8B},
    '{16'h06A9, 16'hFB8E, 16'hFB90, 16'hFB91, 16'hFB8F},
    '{16'h06AF, 16'hFB92, 16'hFB94, 16'hFB95, 16'hFB93},
    '{16'h06BA, 16'hFB9E, 16'hFEE7, 16'hFEE8, 16'hFB9F},
    '{16'h06BE, 16'hFBAA, 16'hFBAC, 16'hFBAD, 16'hFBAB},
    '{16'h06C1, 16'hFBA6, 16'hFBA8, 16'hFBA9, 16'hFBA7},
    '{16'h06CC, 16'hFEEF, 16'hFEF3, 16'hFEF4, 16'hFEF0}
  };

  // alef variant, ligature isolated, ligature final
  localparam logic [15:0] LIGA_TAB [ALEF_ROWS][3] = '{
    '{16'h0622, 16'hFEF5, 16'hFEF6},
    '{16'h0623, 16'hFEF7, 16'hFEF8},
    '{16'h0625, 16'hFEF9, 16'hFEFA},
    '{16'h0627, 16'hFEFB, 16'hFEFC}
  };

  localparam logic [15:0] MARK_TAB [MARK_ROWS] = '{
    16'h0610, 16'h0612, 16'h0613, 16'h0614, 16'h0615, 16'h064B, 16'h064C,
    16'h064D, 16'h064E, 16'h064F, 16'h0650, 16'h0651, 16'h0652, 16'h0653,
    16'h0654, 16'h0655, 16'h0656, 16'h0657, 16'h0658, 16'h0670, 16'h06D6,
    16'h06D7, 16'h06D8, 16'h06D9, 16'h06DA, 16'h06DB, 16'h06DC, 16'h06DF,
    16'h06E0, 16'h06E1, 16'h06E2, 16'h06E3, 16'h06E4, 16'h06E7, 16'h06E8,
    16'h06EA, 16'h06EB, 16'h06EC, 16'h06ED
  };

  function automatic char_info_t char_lookup(input logic [15:0] code);
    char_info_t info;
    info = '0;
    for (int i = 0; i < SHAPE_ROWS; i++) begin
      if (SHAPE_TAB[i][0] == code) begin
        info.is_letter = 1'b1;
        info.isol      = SHAPE_TAB[i][1];
        info.init      = SHAPE_TAB[i][2];
        info.medi      = SHAPE_TAB[i][3];
        info.fina      = SHAPE_TAB[i][4];
      end
    end
    for (int i = 0; i < MARK_ROWS; i++) begin
      if (MARK_TAB[i] == code) begin
        info.is_mark = 1'b1;
      end
    end
    return info;
  endfunction

  function automatic logic joins_next(input char_info_t info, input logic [15:0] code);
    return info.is_letter && ((info.medi != 16'h0000) || (info.fina != 16'h0000) ||
                              (code == TATWEEL));
  endfunction

  function automatic logic joins_prev(input char_info_t info);
    return info.is_letter && ((info.init != 16'h0000) || (info.medi != 16'h0000));
  endfunction

  function automatic logic [15:0] shape_form(input char_info_t info, input logic [15:0] code,
                                             input logic prev, input logic next);
    logic [15:0] form;
    if (!info.is_letter) begin
      form = code;
    end else if (prev && next && (info.medi != 16'h0000)) begin
      form = info.medi;
    end else if (prev && (info.fina != 16'h0000)) begin
      form = info.fina;
    end else if (next && (info.init != 16'h0000)) begin
      form = info.init;
    end else begin
      form = info.isol;
    end
    return form;
  endfunction

  function automatic logic is_alef(input logic [15:0] code);
    logic hit;
    hit = 1'b0;
    for (int i = 0; i < ALEF_ROWS; i++) begin
      if (LIGA_TAB[i][0] == code) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  function automatic logic [15:0] liga_form(input logic [15:0] code, input logic prev);
    logic [15:0] form;
    form = 16'h0000;
    for (int i = 0; i < ALEF_ROWS; i++) begin
      if (LIGA_TAB[i][0] == code) begin
        form = prev ? LIGA_TAB[i][2] : LIGA_TAB[i][1];
      end
    end
    return form;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/arabic_contextual_shaper_unit.sv =====
// Sequence: accept, a table lookup of the new code unit, another of the held letter when
// one is held, a decide state, then the results in order: head, each flushed mark (read,
// then sent), tail. A new code unit is taken only when idle, after all prior results;
// the shared table lookup and the one output register set the pace; results stall on out_ready.
// Reset: rst clears the sequencer, held letter, joining context, mark count and output valid.
// The mark store holds no reset value and is read only at entries written for the held letter.
`timescale 1ns / 1ps
`default_nettype none

module arabic_contextual_shaper_unit #(
  parameter int MAX_MARKS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output      logic        in_ready,
  input  wire logic [15:0] in_code,
  input  wire logic        end_of_text,
  output      logic        out_valid,
  input  wire logic        out_ready,
  output      logic [15:0] out_code,
  output      logic        out_last,
  output      logic        mark_overflow
);

  localparam int CNT_W = $clog2(MAX_MARKS + 1);
  localparam int IDX_W = (MAX_MARKS > 1) ? $clog2(MAX_MARKS) : 1;
  localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MARKS);
  localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

  typedef enum logic [2:0] {
    S_IDLE, S_LOOK_C, S_LOOK_H, S_DECIDE, S_HEAD, S_MARK_RD, S_MARK_TX, S_TAIL
  } state_t;

  typedef struct packed {
    logic        head_v;
    logic [15:0] head;
    logic        flush;
    logic        tail_v;
    logic [15:0] tail;
    logic        ovf;
    logic        store_mark;
    logic        hold_new;
    logic        prior;
  } plan_t;

  state_t                state;
  logic [15:0]           code_q;
  logic                  eot_q;
  acs_pkg::char_info_t   c_info;
  acs_pkg::char_info_t   h_info;
  acs_pkg::char_info_t   lk_info;
  logic [15:0]           lk_code;
  logic [15:0]           held_letter;
  logic                  held_valid;
  logic                  prior_joins;
  logic [CNT_W-1:0]      mark_count;
  logic [CNT_W-1:0]      flush_cnt;
  logic [CNT_W-1:0]      rd_idx;
  logic [CNT_W-1:0]      rd_idx_next;
  logic [CNT_W-1:0]      count_inc;
  logic [15:0]           head_code;
  logic [15:0]           tail_code;
  logic                  tail_v;
  logic                  ovf;
  logic [15:0]           mark_q;
  logic [15:0]           mark_store [MAX_MARKS];
  logic                  slot_free;
  logic                  out_load;
  logic                  pj;
  plan_t                 plan;

  assign in_ready    = (state == S_IDLE);
  assign slot_free   = !out_valid || out_ready;
  assign out_load    = slot_free &&
                       ((state == S_HEAD) || (state == S_MARK_TX) || (state == S_TAIL));
  assign lk_code     = (state == S_LOOK_C) ? code_q : held_letter;
  assign lk_info     = acs_pkg::char_lookup(lk_code);
  assign rd_idx_next = rd_idx + CNT_ONE;
  assign count_inc   = mark_count + CNT_ONE;
  assign pj          = acs_pkg::joins_prev(h_info);

  always_comb begin
    plan       = '0;
    plan.prior = prior_joins;
    if (!held_valid) begin
      if (c_info.is_mark) begin
        plan.head_v = 1'b1;
        plan.head   = code_q;
      end else if (c_info.is_letter) begin
        if (eot_q) begin
          plan.head_v = 1'b1;
          plan.head   = acs_pkg::shape_form(c_info, code_q, prior_joins, 1'b0);
        end else begin
          plan.hold_new = 1'b1;
        end
      end else begin
        plan.head_v = 1'b1;
        plan.head   = code_q;
        plan.prior  = 1'b0;
      end
    end else if (c_info.is_mark) begin
      plan.head = acs_pkg::shape_form(h_info, held_letter, prior_joins, 1'b0);
      if (mark_count < CNT_MAX) begin
        plan.store_mark = 1'b1;
        plan.head_v     = eot_q;
        plan.flush      = eot_q;
      end else begin
        plan.head_v = 1'b1;
        plan.flush  = 1'b1;
        plan.tail_v = 1'b1;
        plan.tail   = code_q;
        plan.ovf    = 1'b1;
        plan.prior  = 1'b0;
      end
    end else if ((held_letter == acs_pkg::LAM) && acs_pkg::is_alef(code_q)) begin
      plan.head_v = 1'b1;
      plan.head   = acs_pkg::liga_form(code_q, prior_joins);
      plan.flush  = 1'b1;
      plan.prior  = 1'b0;
    end else begin
      plan.head_v = 1'b1;
      plan.head   = acs_pkg::shape_form(h_info, held_letter, prior_joins,
                                        acs_pkg::joins_next(c_info, code_q));
      plan.flush  = 1'b1;
      plan.prior  = pj;
      if (c_info.is_letter) begin
        if (eot_q) begin
          plan.tail_v = 1'b1;
          plan.tail   = acs_pkg::shape_form(c_info, code_q, pj, 1'b0);
        end else begin
          plan.hold_new = 1'b1;
        end
      end else begin
        plan.tail_v = 1'b1;
        plan.tail   = code_q;
        plan.prior  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      code_q <= in_code;
      eot_q  <= end_of_text;
    end
    if (state == S_LOOK_C) begin
      c_info <= lk_info;
    end
    if (state == S_LOOK_H) begin
      h_info <= lk_info;
    end
    if (state == S_DECIDE) begin
      head_code <= plan.head;
      tail_code <= plan.tail;
      tail_v    <= plan.tail_v;
      ovf       <= plan.ovf;
      flush_cnt <= plan.store_mark ? count_inc : mark_count;
      if (plan.store_mark) begin
        mark_store[mark_count[IDX_W-1:0]] <= code_q;
      end
    end
    if (state == S_MARK_RD) begin
      mark_q <= mark_store[rd_idx[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      held_letter   <= 16'h0000;
      held_valid    <= 1'b0;
      prior_joins   <= 1'b0;
      mark_count    <= '0;
      rd_idx        <= '0;
      out_valid     <= 1'b0;
      out_code      <= 16'h0000;
      out_last      <= 1'b0;
      mark_overflow <= 1'b0;
    end else begin
      if (out_valid && out_ready && !out_load) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_LOOK_C;
          end
        end
        S_LOOK_C: begin
          state <= held_valid ? S_LOOK_H : S_DECIDE;
        end
        S_LOOK_H: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (eot_q) begin
            held_letter <= 16'h0000;
            held_valid  <= 1'b0;
            prior_joins <= 1'b0;
            mark_count  <= '0;
          end else begin
            prior_joins <= plan.prior;
            if (plan.hold_new) begin
              held_letter <= code_q;
              held_valid  <= 1'b1;
              mark_count  <= '0;
            end else if (plan.flush) begin
              held_valid <= 1'b0;
              mark_count <= '0;
            end else if (plan.store_mark) begin
              mark_count <= count_inc;
            end
          end
          rd_idx <= '0;
          state  <= plan.head_v ? S_HEAD : S_IDLE;
        end
        S_HEAD: begin
          if (slot_free) begin
            out_valid     <= 1'b1;
            out_code      <= head_code;
            mark_overflow <= ovf;
            out_last      <= eot_q && (flush_cnt == '0) && !tail_v;
            if (flush_cnt != '0) begin
              state <= S_MARK_RD;
            end else if (tail_v) begin
              state <= S_TAIL;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_MARK_RD: begin
          state <= S_MARK_TX;
        end
        S_MARK_TX: begin
          if (slot_free) begin
            out_valid     <= 1'b1;
            out_code      <= mark_q;
            mark_overflow <= ovf;
            out_last      <= eot_q && (rd_idx_next == flush_cnt) && !tail_v;
            rd_idx        <= rd_idx_next;
            if (rd_idx_next != flush_cnt) begin
              state <= S_MARK_RD;
            end else if (tail_v) begin
              state <= S_TAIL;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_TAIL: begin
          if (slot_free) begin
            out_valid     <= 1'b1;
            out_code      <= tail_code;
            mark_overflow <= ovf;
            out_last      <= eot_q;
            state         <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    mark_count <= CNT_MAX)
    else $error("mark count beyond buffer depth");

  a_no_marks_without_letter: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE && !held_valid) |-> (mark_count == '0))
    else $error("marks counted with no held letter");

  a_last_clears_context: assert property (@(posedge clk) disable iff (rst)
    (state == S_DECIDE && eot_q) |=> (!held_valid && !prior_joins))
    else $error("string end left joining context behind");

  a_flush_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == S_MARK_TX) |-> (rd_idx < flush_cnt))
    else $error("mark read past flushed count");

endmodule

`default_nettype wire
